// ===== src/ilir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list package
// Shared constants, operation and status codes, and cell control types.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_DROP   = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_e;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic             read_ok;
  } ilir_res_t;

endpackage

// ===== src/ilir_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list request channel
// Valid/ready channel that carries one list request.
// ----------------------------------------------------------------------------
interface ilir_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [5:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

// ===== src/ilir_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list response channel
// Valid/ready channel that carries the result of one list request.
// ----------------------------------------------------------------------------
interface ilir_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [5:0]         count;
  logic [1:0]         status;

  modport source (output valid, output read_value, output count, output status,
                  input ready);
  modport sink (input valid, input read_value, input count, input status,
                output ready);
endinterface

// ===== src/ilir_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one entry and loads a new value or a neighbor's entry on command.
// ----------------------------------------------------------------------------
module ilir_cell (
  input  logic                              clk_i,
  input  ilir_pkg::cell_op_e                op_i,
  input  logic signed [ilir_pkg::DATA_W-1:0] value_i,
  input  logic signed [ilir_pkg::DATA_W-1:0] lower_i,
  input  logic signed [ilir_pkg::DATA_W-1:0] upper_i,
  output logic signed [ilir_pkg::DATA_W-1:0] data_o
);
  import ilir_pkg::*;

  logic signed [DATA_W-1:0] data_d, data_q;

  always_comb begin
    case (op_i)
      CELL_HOLD:       data_d = data_q;
      CELL_LOAD:       data_d = value_i;
      CELL_FROM_LOWER: data_d = lower_i;
      CELL_FROM_UPPER: data_d = upper_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== src/ilir_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list control
// Keeps the entry count, checks each request and commands every cell.
// ----------------------------------------------------------------------------
module ilir_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  ilir_pkg::op_e                 op_i,
  input  logic [ilir_pkg::POS_W-1:0]    pos_i,
  output ilir_pkg::cell_op_e            cell_op_o [ilir_pkg::CAPACITY],
  output ilir_pkg::ilir_res_t           res_o
);
  import ilir_pkg::*;

  logic [CNT_W-1:0] count_d, count_q;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             full, empty, pos_le_cnt, pos_lt_cnt;
  logic             do_append, do_insert, do_remove;
  status_e          status;

  assign pos_x      = CMP_W'(pos_i);
  assign cnt_x      = CMP_W'(count_q);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign pos_le_cnt = (pos_x <= cnt_x);
  assign pos_lt_cnt = (pos_x < cnt_x);

  always_comb begin
    status    = ST_OK;
    count_d   = count_q;
    do_append = 1'b0;
    do_insert = 1'b0;
    do_remove = 1'b0;
    case (op_i)
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_append = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (!pos_le_cnt) begin
          status = ST_BADIDX;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_lt_cnt) begin
          status = ST_BADIDX;
        end
      end
      OP_DROP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!pos_lt_cnt) begin
          status = ST_BADIDX;
        end else begin
          do_remove = 1'b1;
          count_d   = count_q - 1'b1;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op_o[i] = CELL_HOLD;
      if (fire_i) begin
        if (do_append && (CMP_W'(i) == cnt_x)) begin
          cell_op_o[i] = CELL_LOAD;
        end else if (do_insert && (CMP_W'(i) == pos_x)) begin
          cell_op_o[i] = CELL_LOAD;
        end else if (do_insert && (CMP_W'(i) > pos_x)) begin
          cell_op_o[i] = CELL_FROM_LOWER;
        end else if (do_remove && (CMP_W'(i) >= pos_x)) begin
          cell_op_o[i] = CELL_FROM_UPPER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  assign res_o.status  = status;
  assign res_o.count   = count_d;
  assign res_o.read_ok = (op_i == OP_READ) && pos_lt_cnt;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (op_i == OP_CLEAR)) |=> (count_q == '0))
    else $error("Clear did not empty the list.");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status == ST_FULL) |-> full)
    else $error("Full status given on a list that is not full.");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (op_i != OP_CLEAR)) |=>
      (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
      (count_q == $past(count_q) - 1'b1))
    else $error("Entry count moved by more than one.");

endmodule

// ===== src/indexed_list_insert_remove_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list insert/remove unit
// Ordered list of signed entries held in a row of cells that shift together.
// The response is registered in the cycle after the request is taken.
// Throughput: one request per cycle unless a response waits unaccepted;
// every cell loads its neighbor in the same cycle to shift the whole list.
// Reset clears the entry count and the response valid flag; entry contents
// are not reset and are never read before they are written.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilir_req_if.sink    req_i,
  ilir_rsp_if.source  rsp_o
);
  import ilir_pkg::*;

  cell_op_e                 cell_op [CAPACITY];
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  ilir_res_t                res;
  logic                     fire;
  logic signed [DATA_W-1:0] read_value;

  logic                     rsp_valid_q;
  logic signed [DATA_W-1:0] read_value_q;
  logic [CNT_W-1:0]         count_q;
  status_e                  status_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  ilir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .op_i      (op_e'(req_i.operation)),
    .pos_i     (req_i.position),
    .cell_op_o (cell_op),
    .res_o     (res)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_data[g+1];
    end
    ilir_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .value_i (req_i.value),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g])
    );
  end

  assign read_value = res.read_ok ? cell_data[req_i.position[IDX_W-1:0]] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= read_value;
      count_q      <= res.count;
      status_q     <= res.status;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = read_value_q;
  assign rsp_o.count      = count_q;
  assign rsp_o.status     = status_q;

  a_rsp_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_o.valid)
    else $error("Accepted request produced no response.");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !fire)
    else $error("Request taken while a response was still waiting.");

  a_read_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (status_q != ST_OK)) |-> (read_value_q == '0))
    else $error("Failed request returned nonzero read data.");

endmodule

// ===== tb/sv/indexed_list_insert_remove_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list insert/remove unit testbench
// Drives list requests through the request channel and predicts every
// response with a shadow copy of the list. Each response is checked field
// by field against the oldest prediction. Directed corner cases come first,
// then a fill to capacity, a long response stall, a back-to-back burst and
// random phases that favor growing the list, shrinking it or neither.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_unit_test;
  import ilir_pkg::*;

  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         count;
    status_e                  status;
  } list_response_t;

  logic clk;
  logic rst_n;

  ilir_req_if req_if ();
  ilir_rsp_if rsp_if ();

  indexed_list_insert_remove_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_count = 0;
  list_response_t           predicted_responses [$];

  int error_count  = 0;
  int idle_cycles  = 0;
  int hold_request = 0;
  bit no_gaps      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic list_response_t list_apply(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [DATA_W-1:0] val);
    list_response_t r;
    int p;
    p = int'(pos);
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p > shadow_count) begin
          r.status = ST_BADIDX;
        end else begin
          for (int i = shadow_count; i > p; i--) begin
            shadow_entries[i] = shadow_entries[i-1];
          end
          shadow_entries[p] = val;
          shadow_count++;
        end
      end
      OP_READ: begin
        if (p < shadow_count) begin
          r.read_value = shadow_entries[p];
        end else begin
          r.status = ST_BADIDX;
        end
      end
      OP_DROP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_BADIDX;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_count--;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    r.count = POS_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [OP_W-1:0] random_operation(input int grow_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
    if (r < 5) return OP_CLEAR;
    if (r < 30) return OP_READ;
    if ($urandom_range(0, 99) < grow_pct) return $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
    return $urandom_range(0, 1) ? OP_DROP : OP_REMOVE;
  endfunction

  function automatic logic [POS_W-1:0] random_position(input logic [OP_W-1:0] op);
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 63));
    if (op == OP_INSERT) return POS_W'($urandom_range(0, shadow_count));
    if (shadow_count == 0) return '0;
    return POS_W'($urandom_range(0, shadow_count - 1));
  endfunction

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.position  <= pos;
    req_if.value     <= val;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted_responses.push_back(list_apply(op, pos, val));
  endtask

  task automatic send_random_request(input int grow_pct);
    logic [OP_W-1:0] op;
    op = random_operation(grow_pct);
    send_request(op, random_position(op), random_value());
  endtask

  task automatic test_directed();
    send_request(OP_READ, 6'd0, 32'sd0);
    send_request(OP_DROP, 6'd0, 32'sd0);
    send_request(OP_REMOVE, 6'd0, 32'sd0);
    send_request(OP_CLEAR, 6'd0, 32'sd0);
    send_request(OP_INSERT, 6'd1, 32'sd5);
    send_request(OP_INSERT, 6'd0, 32'sh7fff_ffff);
    send_request(OP_APPEND, 6'd63, 32'sh8000_0000);
    send_request(OP_INSERT, 6'd1, 32'sh5555_5555);
    send_request(OP_INSERT, 6'd0, -32'sd1);
    send_request(OP_READ, 6'd0, 32'sd0);
    send_request(OP_READ, 6'd1, 32'sd0);
    send_request(OP_READ, 6'd2, 32'sd0);
    send_request(OP_READ, 6'd3, 32'sd0);
    send_request(OP_READ, 6'd4, 32'sd0);
    send_request(OP_READ, 6'd63, 32'sd0);
    send_request(OP_UNUSED_LO, 6'd0, 32'shaaaa_aaaa);
    send_request(OP_UNUSED_HI, 6'd63, '1);
    send_request(OP_REMOVE, 6'd4, 32'sd0);
    send_request(OP_REMOVE, 6'd1, 32'sd0);
    send_request(OP_REMOVE, 6'd0, 32'sd0);
    send_request(OP_DROP, 6'd0, 32'sd0);
    send_request(OP_READ, 6'd0, 32'sd0);
    send_request(OP_CLEAR, 6'd0, 32'sd0);
  endtask

  task automatic test_full_list();
    while (shadow_count < CAPACITY) begin
      if ($urandom_range(0, 1)) begin
        send_request(OP_APPEND, random_position(OP_APPEND), random_value());
      end else begin
        send_request(OP_INSERT, POS_W'($urandom_range(0, shadow_count)), random_value());
      end
    end
    send_request(OP_APPEND, 6'd0, random_value());
    send_request(OP_INSERT, 6'd63, random_value());
    send_request(OP_INSERT, 6'd0, random_value());
    send_request(OP_READ, POS_W'(CAPACITY - 1), 32'sd0);
    send_request(OP_READ, POS_W'(CAPACITY), 32'sd0);
    send_request(OP_REMOVE, POS_W'(CAPACITY), 32'sd0);
    send_request(OP_REMOVE, POS_W'(CAPACITY - 1), 32'sd0);
    send_request(OP_INSERT, POS_W'(CAPACITY - 1), random_value());
    send_request(OP_REMOVE, 6'd0, 32'sd0);
    send_request(OP_INSERT, 6'd0, random_value());
    send_request(OP_READ, 6'd0, 32'sd0);
    send_request(OP_DROP, 6'd0, 32'sd0);
    send_request(OP_CLEAR, 6'd0, 32'sd0);
  endtask

  task automatic test_response_stall();
    hold_request = HOLD_OFF_CYCLES;
    repeat (40) send_random_request(60);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (150) send_random_request(55);
    no_gaps = 1'b0;
  endtask

  task automatic test_random_phases();
    int grow_pct;
    repeat (10) begin
      case ($urandom_range(0, 2))
        0: grow_pct = 90;
        1: grow_pct = 50;
        default: grow_pct = 15;
      endcase
      repeat (95) send_random_request(grow_pct);
    end
  endtask

  initial begin : response_sink
    list_response_t want;
    int ready_delay;
    int hold_cycles;
    ready_delay = 0;
    hold_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (predicted_responses.size() == 0) begin
          report_mismatch("response without an outstanding request");
        end else begin
          want = predicted_responses.pop_front();
          if (rsp_if.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      rsp_if.read_value, want.read_value));
          if (rsp_if.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", rsp_if.count, want.count));
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
        end
        ready_delay = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (hold_request > 0) begin
        hold_cycles  = hold_request;
        hold_request = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else if (ready_delay > 0) begin
        ready_delay--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= '0;
    req_if.position  <= '0;
    req_if.value     <= '0;
    rsp_if.ready     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_list();
    test_response_stall();
    test_back_to_back();
    test_random_phases();

    req_if.valid <= 1'b0;
    while (predicted_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ilir_pkg.sv
src/ilir_req_if.sv
src/ilir_rsp_if.sv
src/ilir_cell.sv
src/ilir_ctrl.sv
src/indexed_list_insert_remove_unit.sv
tb/sv/indexed_list_insert_remove_unit_test.sv
